>>> hdl/vn2dh_pkg.sv
// ----------------------------------------------------------------------------
// vn2dh_pkg
// Constants shared by the hashed 2-D value noise pipeline.
// ----------------------------------------------------------------------------
package vn2dh_pkg;

    // lattice hash: per-axis multipliers and the two mixing multipliers
    localparam logic [31:0] HASH_XM  = 32'h9e3779b9;
    localparam logic [31:0] HASH_ZM  = 32'h85ebca6b;
    localparam logic [31:0] MIX_M1   = 32'h7feb352d;
    localparam logic [31:0] MIX_M2   = 32'h846ca68b;

    localparam int unsigned NUM_CORNERS = 4;
    localparam int unsigned NUM_STAGES  = 9;

    typedef logic [31:0]        word_t;
    typedef logic signed [15:0] corner_t;

endpackage

>>> hdl/value_noise_2d_hashed.sv
// ----------------------------------------------------------------------------
// value_noise_2d_hashed
// Nine-stage pipeline: lattice hash of four cell corners, smoothstep weights,
// bilinear blend of the corner values.
// ----------------------------------------------------------------------------
//  channel   | ports                          | handshake
//  ----------+--------------------------------+------------------------------
//  request   | x_pos, z_pos                   | start high, busy low
//  result    | noise_out                      | noise_valid strobe, one cycle
//  seed      | noise_seed                     | seed_we, write at clock edge
//
// One request per cycle; each result passes the chain of hash multiplies
// (axis, mix 1, mix 2) and the two blend multiplies. busy stays low: the
// receiver cannot stall, so the pipeline never holds. Reset clears the valid
// bits and the seed.
// ----------------------------------------------------------------------------
module value_noise_2d_hashed #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] x_pos,
    input  logic signed [31:0] z_pos,
    output logic               noise_valid,
    output logic signed [15:0] noise_out,
    input  logic               seed_we,
    input  logic [31:0]        noise_seed
);
    import vn2dh_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int PW = F + 18;     // (17-bit signed diff) x (F+1-bit signed weight)

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    word_t                 seed_reg;

    // stage 1
    word_t        pa_reg, pb_reg;
    logic [2*F-1:0] txx_reg, tzz_reg;
    logic [F-1:0] tx_reg, tz_reg;
    // stage 2
    word_t        v2_reg [NUM_CORNERS];
    logic [F-1:0] sx2_reg, sz2_reg;
    // stage 3..5
    word_t        m1_reg [NUM_CORNERS];
    word_t        m2_reg [NUM_CORNERS];
    corner_t      c_reg  [NUM_CORNERS];
    logic [F-1:0] sx3_reg, sz3_reg, sx4_reg, sz4_reg, sx5_reg, sz5_reg;
    // stage 6..9
    logic signed [PW-1:0] ptop_reg, pbot_reg, pz_reg;
    corner_t      c00_6_reg, c01_6_reg, top_reg, bot_reg, top8_reg, out_reg;
    logic [F-1:0] sz6_reg, sz7_reg;

    // combinational helpers
    word_t        cx, cz;
    word_t        pax1, pbz1;
    word_t        v_mix [NUM_CORNERS];
    word_t        m1x   [NUM_CORNERS];
    word_t        hfin  [NUM_CORNERS];
    logic [F+1:0] k3, kx, kz;
    logic [2*F+1:0] smx, smz;
    logic signed [16:0] d_top, d_bot, d_z;
    logic signed [PW-1:0] top_sum, bot_sum, out_sum;

    assign busy        = 1'b0;
    assign noise_valid = vld_reg[NUM_STAGES-1];
    assign noise_out   = out_reg;

    assign vld_next = {vld_reg[NUM_STAGES-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            seed_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (seed_we)
            begin
                seed_reg <= noise_seed;
            end
        end
    end

    always_comb
    begin
        cx = word_t'(x_pos >>> F);
        cz = word_t'(z_pos >>> F);
        // corner +1 products follow from the base products
        pax1 = pa_reg + HASH_XM;
        pbz1 = pb_reg + HASH_ZM;
        v_mix[0] = pa_reg ^ pb_reg ^ seed_reg;
        v_mix[1] = pax1   ^ pb_reg ^ seed_reg;
        v_mix[2] = pa_reg ^ pbz1   ^ seed_reg;
        v_mix[3] = pax1   ^ pbz1   ^ seed_reg;
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            v_mix[i] = v_mix[i] ^ (v_mix[i] >> 16);
            m1x[i]   = m1_reg[i] ^ (m1_reg[i] >> 15);
            hfin[i]  = m2_reg[i] ^ (m2_reg[i] >> 16);
        end
        // smoothstep: floor(t*t/2^F) * (3*2^F - 2t) / 2^F
        k3  = {2'b11, {F{1'b0}}};
        kx  = k3 - {1'b0, tx_reg, 1'b0};
        kz  = k3 - {1'b0, tz_reg, 1'b0};
        smx = txx_reg[2*F-1:F] * kx;
        smz = tzz_reg[2*F-1:F] * kz;
        // blend differences
        d_top = 17'(c_reg[1]) - 17'(c_reg[0]);
        d_bot = 17'(c_reg[3]) - 17'(c_reg[2]);
        d_z   = 17'(bot_reg)  - 17'(top_reg);
        top_sum = PW'(c00_6_reg) + (ptop_reg >>> F);
        bot_sum = PW'(c01_6_reg) + (pbot_reg >>> F);
        out_sum = PW'(top8_reg)  + (pz_reg >>> F);
    end

    always_ff @(posedge clk)
    begin
        // stage 1: axis products, fractions, squares
        pa_reg  <= cx * HASH_XM;
        pb_reg  <= cz * HASH_ZM;
        tx_reg  <= x_pos[F-1:0];
        tz_reg  <= z_pos[F-1:0];
        txx_reg <= x_pos[F-1:0] * x_pos[F-1:0];
        tzz_reg <= z_pos[F-1:0] * z_pos[F-1:0];
        // stage 2: seeded corner words, smoothstep weights
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            v2_reg[i] <= v_mix[i];
        end
        sx2_reg <= smx[2*F-1:F];
        sz2_reg <= smz[2*F-1:F];
        // stages 3..5: mix rounds, corner values
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            m1_reg[i] <= v2_reg[i] * MIX_M1;
            m2_reg[i] <= m1x[i] * MIX_M2;
            c_reg[i]  <= {~hfin[i][15], hfin[i][14:0]};
        end
        sx3_reg <= sx2_reg;
        sz3_reg <= sz2_reg;
        sx4_reg <= sx3_reg;
        sz4_reg <= sz3_reg;
        sx5_reg <= sx4_reg;
        sz5_reg <= sz4_reg;
        // stage 6: x blend products, operands widened to the full product
        ptop_reg  <= PW'(d_top) * PW'($signed({1'b0, sx5_reg}));
        pbot_reg  <= PW'(d_bot) * PW'($signed({1'b0, sx5_reg}));
        c00_6_reg <= c_reg[0];
        c01_6_reg <= c_reg[2];
        sz6_reg   <= sz5_reg;
        // stage 7: top and bottom rows
        top_reg <= top_sum[15:0];
        bot_reg <= bot_sum[15:0];
        sz7_reg <= sz6_reg;
        // stage 8: z blend product
        pz_reg   <= PW'(d_z) * PW'($signed({1'b0, sz7_reg}));
        top8_reg <= top_reg;
        // stage 9: result
        out_reg <= out_sum[15:0];
    end

endmodule

>>> verif/value_noise_2d_hashed_tb.sv
// ----------------------------------------------------------------------------
// value_noise_2d_hashed_tb
// Self-checking bench for the hashed 2-D value noise pipeline. A directed
// table of lattice, range-end and other fixed points runs first, then random
// points under several seeds. Results are compared with a lattice-hash and
// smoothstep blend predictor in the bench; known table rows use their value.
// ----------------------------------------------------------------------------
module value_noise_2d_hashed_tb;

    localparam int FRAC_BITS    = 16;
    localparam int LATENCY      = 9;
    localparam int STALL_LIMIT  = 500;
    localparam int PHASE_POINTS = 230;
    localparam int NUM_SEEDS    = 6;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] z;
        logic        known;
        logic [15:0] noise;
    } point_row_t;

    localparam int NUM_ROWS = 18;
    // seed is still at reset here; a point on the lattice gives its corner value
    localparam point_row_t POINT_TABLE [NUM_ROWS] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 16'h8000},
        '{32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 16'h0000},
        '{32'h8000_0000, 32'h8000_0000, 1'b0, 16'h0000},
        '{32'h7fff_ffff, 32'h8000_0000, 1'b0, 16'h0000},
        '{32'h8000_0000, 32'h7fff_ffff, 1'b0, 16'h0000},
        '{32'h0000_ffff, 32'h0000_ffff, 1'b0, 16'h0000},
        '{32'hffff_ffff, 32'hffff_ffff, 1'b0, 16'h0000},
        '{32'h0000_8000, 32'h0000_8000, 1'b0, 16'h0000},
        '{32'h0000_0001, 32'h0000_0001, 1'b0, 16'h0000},
        '{32'h0001_0000, 32'h0000_0000, 1'b0, 16'h0000},
        '{32'hffff_0000, 32'h0001_0000, 1'b0, 16'h0000},
        '{32'h0000_c000, 32'h0000_4000, 1'b0, 16'h0000},
        '{32'h7fff_8000, 32'hffff_8000, 1'b0, 16'h0000},
        '{32'h1234_5678, 32'h9abc_def0, 1'b0, 16'h0000},
        '{32'h5555_5555, 32'haaaa_aaaa, 1'b0, 16'h0000},
        '{32'haaaa_aaaa, 32'h5555_5555, 1'b0, 16'h0000},
        '{32'hfffe_0001, 32'h0001_ffff, 1'b0, 16'h0000},
        '{32'h8000_ffff, 32'h7fff_0000, 1'b0, 16'h0000}
    };

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] x_pos;
    logic signed [31:0] z_pos;
    logic               noise_valid;
    logic signed [15:0] noise_out;
    logic               seed_we;
    logic [31:0]        noise_seed;

    logic signed [15:0] noise_expect_q [$];
    logic [31:0]        seed_model;
    int                 mismatch_count;
    int                 stall_cycles;
    int                 burst_left;

    value_noise_2d_hashed #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .x_pos       (x_pos),
        .z_pos       (z_pos),
        .noise_valid (noise_valid),
        .noise_out   (noise_out),
        .seed_we     (seed_we),
        .noise_seed  (noise_seed)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] avalanche(logic [31:0] v);
        v = v ^ (v >> 16);
        v = v * 32'h7feb352d;
        v = v ^ (v >> 15);
        v = v * 32'h846ca68b;
        return v ^ (v >> 16);
    endfunction

    function automatic longint lattice_value(logic [31:0] cx, logic [31:0] cz,
                                             logic [31:0] seed);
        logic [31:0] h;
        h = avalanche((cx * 32'h9e3779b9) ^ (cz * 32'h85ebca6b) ^ seed);
        return longint'(h[15:0]) - 32768;
    endfunction

    function automatic longint fade(logic [31:0] pos);
        longint t;
        longint t2;
        t  = longint'(pos[FRAC_BITS-1:0]);
        t2 = (t * t) >>> FRAC_BITS;
        return (t2 * ((longint'(3) << FRAC_BITS) - 2 * t)) >>> FRAC_BITS;
    endfunction

    // arithmetic shift of a signed product floors toward minus infinity
    function automatic longint blend(longint a, longint b, longint w);
        return a + (((b - a) * w) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [15:0] noise_at(logic [31:0] xp, logic [31:0] zp,
                                                    logic [31:0] seed);
        logic [31:0] cx;
        logic [31:0] cz;
        longint      wx;
        longint      top;
        longint      bottom;
        cx     = $signed(xp) >>> FRAC_BITS;
        cz     = $signed(zp) >>> FRAC_BITS;
        wx     = fade(xp);
        top    = blend(lattice_value(cx, cz, seed), lattice_value(cx + 1, cz, seed), wx);
        bottom = blend(lattice_value(cx, cz + 1, seed),
                       lattice_value(cx + 1, cz + 1, seed), wx);
        return 16'(blend(top, bottom, fade(zp)));
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] random_pos();
        logic [31:0] p;
        case ($urandom_range(0, 5))
            0: p = 32'($urandom_range(0, 32'h001f_ffff)) - 32'h0010_0000;
            1: p = 32'h7fff_ffff - 32'($urandom_range(0, 32'h0003_ffff));
            2: p = 32'h8000_0000 + 32'($urandom_range(0, 32'h0003_ffff));
            3: p = {16'($urandom), 16'h0000};
            4:
            begin
                case ($urandom_range(0, 3))
                    0: p = {16'($urandom), 16'h0001};
                    1: p = {16'($urandom), 16'hffff};
                    2: p = {16'($urandom), 16'h8000};
                    default: p = {16'($urandom), 16'hfffe};
                endcase
            end
            default: p = $urandom;
        endcase
        return p;
    endfunction

    // drive one request and hold it until accepted, then idle for a drawn gap
    task automatic send_point(logic [31:0] xp, logic [31:0] zp, logic check_fixed,
                              logic [15:0] fixed_noise);
        int gap;
        start <= 1'b1;
        x_pos <= xp;
        z_pos <= zp;
        do
            @(posedge clk);
        while (busy);
        if (check_fixed)
            noise_expect_q.push_back(fixed_noise);
        else
            noise_expect_q.push_back(noise_at(xp, zp, seed_model));
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0)
                burst_left = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge clk);
        while (noise_expect_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic load_seed(logic [31:0] seed);
        seed_we    <= 1'b1;
        noise_seed <= seed;
        @(posedge clk);
        seed_we    <= 1'b0;
        noise_seed <= $urandom;
        seed_model = seed;
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && noise_valid)
        begin
            if (noise_expect_q.size() == 0)
            begin
                $error("noise_out: expected none, got %0d", noise_out);
                mismatch_count++;
            end
            else
            begin
                logic signed [15:0] want;
                want = noise_expect_q.pop_front();
                if (noise_out !== want)
                begin
                    $error("noise_out: expected %0d, got %0d", want, noise_out);
                    mismatch_count++;
                end
            end
        end
    end

    // cycles with neither a request nor a result accepted
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || noise_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] seeds [NUM_SEEDS];
        seeds[0] = 32'hffff_ffff;
        seeds[1] = $urandom;
        seeds[2] = 32'h8000_0000;
        seeds[3] = $urandom;
        seeds[4] = 32'h0000_0001;
        seeds[5] = 32'h0000_0000;

        mismatch_count = 0;
        stall_cycles   = 0;
        burst_left     = 0;
        seed_model     = 32'h0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        x_pos      <= '0;
        z_pos      <= '0;
        seed_we    <= 1'b0;
        noise_seed <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_point(POINT_TABLE[i].x, POINT_TABLE[i].z, POINT_TABLE[i].known,
                       POINT_TABLE[i].noise);

        for (int s = 0; s < NUM_SEEDS; s++)
        begin
            drain_pipe();
            load_seed(seeds[s]);
            for (int n = 0; n < PHASE_POINTS; n++)
                send_point(random_pos(), random_pos(), 1'b0, 16'h0);
        end

        drain_pipe();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
